@@ rtl/wmf_pkg.sv @@
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared field width and type for the sliding-window mode filter and its channels.
// ----------------------------------------------------------------------------
package wmf_pkg;

	// width of the sample and mode_value fields on the channels
	localparam int unsigned FIELD_BITS = 16;

	typedef logic [FIELD_BITS-1:0] field_t;

endpackage

@@ rtl/wmf_in_if.sv @@
// ----------------------------------------------------------------------------
// wmf_in_if
// Request channel of the mode filter: one sample and its store flag.
// ----------------------------------------------------------------------------
interface wmf_in_if;

	logic            valid;
	logic            ready;
	wmf_pkg::field_t sample;
	logic            store;

	modport source (output valid, output sample, output store, input ready);
	modport sink   (input valid, input sample, input store, output ready);

endinterface

@@ rtl/wmf_out_if.sv @@
// ----------------------------------------------------------------------------
// wmf_out_if
// Result channel of the mode filter: the mode of the window.
// ----------------------------------------------------------------------------
interface wmf_out_if;

	logic            valid;
	logic            ready;
	wmf_pkg::field_t mode_value;

	modport source (output valid, output mode_value, input ready);
	modport sink   (input valid, input mode_value, output ready);

endinterface

@@ rtl/window_mode_filter_core.sv @@
// ----------------------------------------------------------------------------
// window_mode_filter_core
// Keeps the last WINDOW samples in a ring memory and reports the mode of the
// window for every request, earliest slot winning ties.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                 meaning
//  req      in   sample[15:0], store    sample, written to the ring if store
//  rsp      out  mode_value[15:0]       most frequent value in the window
//
//  one request at a time; each request scans the ring memory through its
//  single read port: each slot is read once as candidate and once per
//  compare, plus a load, a drain and a tally step per candidate
//  reset empties the ring at once through per-entry valid bits (invalid reads
//  as zero), so no clearing pass is needed
//  the result sits in an output register; the next request is taken while it
//  waits, and the scan stalls at its end only if that register is still full
//
module window_mode_filter_core #(
	parameter int unsigned WINDOW      = 10,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	wmf_in_if.sink   req,
	wmf_out_if.source rsp
);

	localparam int unsigned IDX_W = $clog2(WINDOW);
	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam int unsigned FB    = wmf_pkg::FIELD_BITS;

	typedef logic [SAMPLE_BITS-1:0] word_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_CAND,
		ST_LD_CAND,
		ST_SCAN,
		ST_TALLY,
		ST_DONE
	} state_t;

	// ring memory and its per-entry valid bits
	word_t                mem [WINDOW];
	logic  [WINDOW-1:0]   valid_q;
	idx_t                 wr_slot_q;

	// read port
	idx_t  rd_addr;
	word_t rd_data_s1;
	logic  rd_vld_s1;
	word_t rd_eff;

	// scan control
	state_t state_q;
	idx_t   cand_q;
	cnt_t   pos_q;
	logic   cmp_pend_s1;
	word_t  cur_q;
	cnt_t   cnt_q;
	cnt_t   best_cnt_q;
	word_t  best_q;

	logic                 out_valid_q;
	wmf_pkg::field_t      mode_q;

	logic                 accept;
	logic [SAMPLE_BITS+FB-1:0] sample_ext;
	logic [SAMPLE_BITS+FB-1:0] best_ext;

	assign accept     = req.valid && req.ready;
	assign sample_ext = {{SAMPLE_BITS{1'b0}}, req.sample};
	assign best_ext   = {{FB{1'b0}}, best_q};

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.mode_value = mode_q;

	assign rd_eff = rd_vld_s1 ? rd_data_s1 : '0;

	always_comb begin
		unique case (state_q)
			ST_RD_CAND: rd_addr = cand_q;
			// the last scan cycle only drains the pipe; its read of slot 0 is not used
			ST_SCAN:    rd_addr = (pos_q == cnt_t'(WINDOW)) ? '0 : pos_q[IDX_W-1:0];
			default:    rd_addr = '0;
		endcase
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && req.store) begin
			mem[wr_slot_q] <= sample_ext[SAMPLE_BITS-1:0];
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			wr_slot_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= valid_q[rd_addr];
			if (accept && req.store) begin
				valid_q[wr_slot_q] <= 1'b1;
				if (wr_slot_q == idx_t'(WINDOW - 1)) begin
					wr_slot_q <= '0;
				end else begin
					wr_slot_q <= wr_slot_q + idx_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cand_q      <= '0;
			pos_q       <= '0;
			cmp_pend_s1 <= 1'b0;
			cnt_q       <= '0;
			best_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			best_q      <= '0;
			mode_q      <= '0;
		end else begin
			if (out_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cand_q     <= '0;
						best_cnt_q <= '0;
						state_q    <= ST_RD_CAND;
					end
				end
				ST_RD_CAND: begin
					state_q <= ST_LD_CAND;
				end
				ST_LD_CAND: begin
					// candidate arrives while the read of slot 0 goes out
					cur_q       <= rd_eff;
					cnt_q       <= '0;
					pos_q       <= '0;
					cmp_pend_s1 <= 1'b0;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cmp_pend_s1 && (rd_eff == cur_q)) begin
						cnt_q <= cnt_q + cnt_t'(1);
					end
					if (pos_q == cnt_t'(WINDOW)) begin
						cmp_pend_s1 <= 1'b0;
						state_q     <= ST_TALLY;
					end else begin
						cmp_pend_s1 <= 1'b1;
						pos_q       <= pos_q + cnt_t'(1);
					end
				end
				ST_TALLY: begin
					// strict compare keeps the earliest slot on a tie
					if (cnt_q > best_cnt_q) begin
						best_cnt_q <= cnt_q;
						best_q     <= cur_q;
					end
					if (cand_q == idx_t'(WINDOW - 1)) begin
						state_q <= ST_DONE;
					end else begin
						cand_q  <= cand_q + idx_t'(1);
						state_q <= ST_RD_CAND;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						mode_q      <= best_ext[FB-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
